// ===== hdl/mtrg_pkg.sv =====
package mtrg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int WORD_W       = 32;
	localparam int CNT_W        = $clog2(STATE_WORDS);

	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
	localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

	localparam logic CMD_DRAW   = 1'b0;
	localparam logic CMD_RESEED = 1'b1;

	// source of the word entering the end of the chain
	typedef enum logic [1:0] {
		FB_LOAD,
		FB_CHAIN,
		FB_TWIST
	} fb_mode_t;

	typedef struct packed {
		fb_mode_t          mode;
		logic [WORD_W-1:0] load_word;
		logic [CNT_W-1:0]  chain_idx;
	} fb_ctrl_t;

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ===== hdl/mtrg_cell.sv =====
module mtrg_cell import mtrg_pkg::*; (
	input  logic              clk,
	input  logic              shift,
	input  logic [WORD_W-1:0] d,
	output logic [WORD_W-1:0] q
);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// ===== hdl/mtrg_feedback.sv =====
module mtrg_feedback import mtrg_pkg::*; (
	input  fb_ctrl_t          ctrl,
	input  logic [WORD_W-1:0] head,
	input  logic [WORD_W-1:0] next,
	input  logic [WORD_W-1:0] far,
	input  logic [WORD_W-1:0] tail,
	output logic [WORD_W-1:0] new_word
);

	logic [WORD_W-1:0] y;
	logic [WORD_W-1:0] twisted;
	logic [WORD_W-1:0] chained;

	// twist of the oldest word against its successor and the far tap
	assign y       = {head[WORD_W-1], next[WORD_W-2:0]};
	assign twisted = far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);

	// seed chain from the word shifted in last
	assign chained = SEED_MULT * (tail ^ (tail >> 30))
		+ {{(WORD_W-CNT_W){1'b0}}, ctrl.chain_idx};

	always_comb begin
		case (ctrl.mode)
			FB_LOAD:  new_word = ctrl.load_word;
			FB_CHAIN: new_word = chained;
			FB_TWIST: new_word = twisted;
			default:  new_word = twisted;
		endcase
	end

endmodule

// ===== hdl/mt19937_random_generator_top.sv =====
// mt19937 pseudo-random word generator
//
// input channel (in_valid / in_ready, command, seed): command draw asks for
// the next tempered 32-bit word, command reseed refills the state from seed
// and gives no result. output channel (out_valid / out_ready, random_word)
// carries one word per draw.
//
// the state lives in a chain of 624 word cells that shift toward cell 0. a
// draw twists the oldest word against cells 1 and 397, shifts the result in
// at the tail and tempers it into the output register: one draw per cycle
// while the receiver keeps up, result valid the cycle after the transfer.
// a reseed shifts in the seed with its transfer, then one multiply-chain word
// per cycle through the seed multiplier until full; no transfer is taken.
//
// after reset the chain is unseeded; the first draw waits while the chain is
// seeded with 5489, then is taken as usual.
// when the receiver stalls, the word waits in the output register; further
// draws are held off until it is taken, reseeds are still taken.
module mt19937_random_generator_top import mtrg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [WORD_W-1:0] seed,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] random_word
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEED = 2'b10
	} state_t;

	state_t            state_q;
	logic              seeded_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] random_word_q;

	logic [WORD_W-1:0] chain_word [STATE_WORDS];
	logic [WORD_W-1:0] new_word;
	logic              shift;
	logic              slot_free;
	logic              idle;
	logic              in_xfer;
	logic              draw_xfer;
	logic              reseed_xfer;
	logic              auto_seed;
	logic              seed_last;
	fb_ctrl_t          fb_ctrl;

	assign idle      = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	// a draw is taken only once the chain holds a seeded state
	assign in_ready    = idle && ((command == CMD_RESEED) || (seeded_q && slot_free));
	assign in_xfer     = in_valid && in_ready;
	assign draw_xfer   = in_xfer && (command == CMD_DRAW);
	assign reseed_xfer = in_xfer && (command == CMD_RESEED);

	// pending draw on an unseeded chain starts the default seeding
	assign auto_seed = idle && in_valid && (command == CMD_DRAW) && !seeded_q;
	assign seed_last = (cnt_q == CNT_W'(STATE_WORDS - 1));

	always_comb begin
		fb_ctrl.mode      = FB_TWIST;
		fb_ctrl.load_word = reseed_xfer ? seed : DEFAULT_SEED;
		fb_ctrl.chain_idx = cnt_q;
		if (state_q == ST_SEED) begin
			fb_ctrl.mode = FB_CHAIN;
		end else if (reseed_xfer || auto_seed) begin
			fb_ctrl.mode = FB_LOAD;
		end
	end

	assign shift = draw_xfer || reseed_xfer || auto_seed || (state_q == ST_SEED);

	mtrg_feedback u_feedback (
		.ctrl     (fb_ctrl),
		.head     (chain_word[0]),
		.next     (chain_word[1]),
		.far      (chain_word[TWIST_OFFSET]),
		.tail     (chain_word[STATE_WORDS-1]),
		.new_word (new_word)
	);

	// word cells, tail fed by the feedback unit
	for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
		logic [WORD_W-1:0] d;
		if (i == STATE_WORDS - 1) begin : g_tail
			assign d = new_word;
		end else begin : g_body
			assign d = chain_word[i+1];
		end
		mtrg_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.d     (d),
			.q     (chain_word[i])
		);
	end

	// seeding sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			seeded_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (reseed_xfer || auto_seed) begin
						state_q  <= ST_SEED;
						seeded_q <= 1'b0;
						cnt_q    <= CNT_W'(1);
					end
				end
				ST_SEED: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (seed_last) begin
						state_q  <= ST_IDLE;
						seeded_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_xfer) begin
			random_word_q <= temper(new_word);
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

endmodule
